// File: rtl/core/ots_pkg.sv
// Shared types and constants for the threshold search block.
`timescale 1ns / 1ps
`default_nettype none
package ots_pkg;

    localparam int DivNumW = 57;
    localparam int DivDenW = 33;
    localparam int DivSteps = DivNumW;
    localparam int DivCntW = $clog2(DivSteps);
    localparam int AccW = DivNumW + 1;

    localparam logic [31:0] InfScore = 32'hFFFF_FFFF;
    localparam logic [31:0] MaxFinite = 32'hFFFF_FFFE;
    localparam logic [32:0] OneQ16 = 33'h0_0001_0000;
    localparam logic [31:0] ParamReset = 32'h0100_0000;

    localparam logic [1:0] CritWeighted = 2'd0;
    localparam logic [1:0] CritNoPrior = 2'd1;
    localparam logic [1:0] CritLimitC1 = 2'd2;
    localparam logic [1:0] CritLimitC0 = 2'd3;

    localparam logic [1:0] RegCriterion = 2'd0;
    localparam logic [1:0] RegTradeoff = 2'd1;
    localparam logic [1:0] RegTotal0 = 2'd2;
    localparam logic [1:0] RegTotal1 = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_COMPARE,
        ST_UPDATE,
        ST_MUL,
        ST_DIV_A,
        ST_WAIT_A,
        ST_DIV_B,
        ST_WAIT_B,
        ST_SCORE,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic capture;
        logic init;
        logic compare;
        logic update;
        logic mul;
        logic div_a;
        logic div_b;
        logic acc_add;
        logic set_first;
        logic set_pending;
        logic final_out;
    } cmd_t;

    typedef struct packed {
        logic inf;
        logic no_prior;
        logic div_done;
        logic last;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

// File: rtl/core/ots_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ots_div
    import ots_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DivNumW-1:0] numer,
    input  wire logic [DivDenW-1:0] denom,
    output logic                    done,
    output logic [DivNumW-1:0]      quot
);

    logic [DivNumW-1:0] num_reg;
    logic [DivDenW-1:0] den_reg;
    logic [DivDenW-1:0] rem_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DivDenW:0]   trial;
    logic [DivDenW:0]   diff;
    logic               ge;

    assign trial = {rem_reg, num_reg[DivNumW-1]};
    assign diff = trial - {1'b0, den_reg};
    assign ge = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DivCntW'(DivSteps - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DivNumW-2:0], ge};
            rem_reg <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule
`default_nettype wire

// File: rtl/core/ots_datapath.sv
// Weights, scoring arithmetic, best-split tracking and result register.
`timescale 1ns / 1ps
`default_nettype none
module ots_datapath
    import ots_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output status_t          status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_class,
    input  wire logic [31:0] in_value,
    input  wire logic [31:0] in_weight,
    input  wire logic        in_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_threshold,
    output logic [31:0]      out_score
);

    logic [1:0]        crit_reg;
    logic [31:0]       param_reg;
    logic [31:0]       t0_reg;
    logic [31:0]       t1_reg;
    logic              cls_reg;
    logic [31:0]       val_reg;
    logic [31:0]       wgt_reg;
    logic              last_reg;
    logic [31:0]       w0_reg;
    logic [31:0]       w1_reg;
    logic [31:0]       pend_reg;
    logic [31:0]       prev_reg;
    logic [31:0]       bscore_reg;
    logic [31:0]       bthr_reg;
    logic [63:0]       prod_reg;
    logic [AccW-1:0]   acc_reg;
    logic              inf_reg;
    logic              ovalid_reg;
    logic [31:0]       othr_reg;
    logic [31:0]       oscore_reg;

    logic [31:0]        mul_op;
    logic [32:0]        tsum;
    logic [40:0]        num_c0;
    logic               inf_c;
    logic [DivNumW-1:0] numer;
    logic [DivDenW-1:0] denom;
    logic               div_start;
    logic               div_done;
    logic [DivNumW-1:0] quot;
    logic [31:0]        score;
    logic [32:0]        w1_sum;
    logic [32:0]        mid_sum;
    logic [31:0]        thr_lo;
    logic [31:0]        thr_hi;
    logic               fin_better;

    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

    always_comb
    begin
        case (crit_reg)
            CritLimitC1: mul_op = t1_reg;
            CritLimitC0: mul_op = t0_reg;
            default:     mul_op = w1_reg;
        endcase
    end

    assign tsum = {1'b0, t0_reg} + {1'b0, t1_reg};
    assign num_c0 = {9'b0, w0_reg} + {1'b0, prod_reg[63:24]};

    always_comb
    begin
        case (crit_reg)
            CritWeighted:
            begin
                inf_c = tsum == '0;
                numer = {num_c0, 16'b0};
                denom = tsum;
            end
            CritNoPrior:
            begin
                inf_c = (t0_reg == '0) || (t1_reg == '0);
                numer = {9'b0, w0_reg, 16'b0};
                denom = {1'b0, t0_reg};
            end
            CritLimitC1:
            begin
                inf_c = ({8'b0, w1_reg, 24'b0} > prod_reg) || (t0_reg == '0);
                numer = {9'b0, w0_reg, 16'b0};
                denom = {1'b0, t0_reg};
            end
            default:
            begin
                inf_c = ({8'b0, w0_reg, 24'b0} > prod_reg) || (t1_reg == '0);
                numer = {9'b0, w1_reg, 16'b0};
                denom = {1'b0, t1_reg};
            end
        endcase
        if (cmd.div_b)
        begin
            numer = {1'b0, prod_reg[63:8]};
            denom = {1'b0, t1_reg};
        end
    end

    assign div_start = (cmd.div_a && !inf_c) || cmd.div_b;

    ots_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (denom),
        .done  (div_done),
        .quot  (quot)
    );

    assign score = inf_reg ? InfScore :
                   (acc_reg > AccW'(MaxFinite)) ? MaxFinite : acc_reg[31:0];
    assign w1_sum = {1'b0, w1_reg} + {1'b0, wgt_reg};
    assign mid_sum = {prev_reg[31], prev_reg} + {val_reg[31], val_reg};
    assign thr_lo = sat33({val_reg[31], val_reg} - OneQ16);
    assign thr_hi = sat33({val_reg[31], val_reg} + OneQ16);
    assign fin_better = pend_reg < bscore_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_reg <= CritWeighted;
            param_reg <= ParamReset;
            t0_reg <= '0;
            t1_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    RegCriterion: crit_reg <= cfg_data[1:0];
                    RegTradeoff:  param_reg <= cfg_data;
                    RegTotal0:    t0_reg <= cfg_data;
                    RegTotal1:    t1_reg <= cfg_data;
                    default:      crit_reg <= crit_reg;
                endcase
            end
            if (cmd.final_out)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cls_reg <= in_class;
            val_reg <= in_value;
            wgt_reg <= in_weight;
            last_reg <= in_last;
        end
        if (cmd.init)
        begin
            w0_reg <= t0_reg;
            w1_reg <= '0;
        end
        if (cmd.update)
        begin
            if (cls_reg)
                w1_reg <= w1_sum[32] ? 32'hFFFF_FFFF : w1_sum[31:0];
            else
                w0_reg <= (w0_reg > wgt_reg) ? w0_reg - wgt_reg : '0;
        end
        if (cmd.mul)
            prod_reg <= 64'(param_reg) * 64'(mul_op);
        if (cmd.div_a)
        begin
            inf_reg <= inf_c;
            acc_reg <= '0;
        end
        if (cmd.acc_add)
            acc_reg <= acc_reg + {1'b0, quot};
        if (cmd.set_first)
        begin
            bscore_reg <= score;
            bthr_reg <= thr_lo;
        end
        if (cmd.compare && fin_better)
        begin
            bscore_reg <= pend_reg;
            bthr_reg <= mid_sum[32:1];
        end
        if (cmd.set_pending)
        begin
            pend_reg <= score;
            prev_reg <= val_reg;
        end
        if (cmd.final_out)
        begin
            if (fin_better)
            begin
                bscore_reg <= pend_reg;
                bthr_reg <= thr_hi;
            end
            oscore_reg <= fin_better ? pend_reg : bscore_reg;
            othr_reg <= fin_better ? thr_hi : bthr_reg;
        end
    end

    assign status.inf = inf_c;
    assign status.no_prior = crit_reg == CritNoPrior;
    assign status.div_done = div_done;
    assign status.last = last_reg;
    assign status.out_busy = ovalid_reg && !out_ready;

    assign out_valid = ovalid_reg;
    assign out_threshold = othr_reg;
    assign out_score = oscore_reg;

    a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> denom != '0)
        else $error("divider started with zero divisor");

    a_final_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_out |=> ovalid_reg)
        else $error("result not presented after final transaction");

    a_final_not_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_out |-> !(ovalid_reg && !out_ready))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// File: rtl/core/ots_ctrl.sv
// Sequencer for sample capture, scoring steps and result emission.
`timescale 1ns / 1ps
`default_nettype none
module ots_ctrl
    import ots_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   first_reg;
    logic   first_next;
    logic   phase_reg;
    logic   phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b1;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        phase_next = phase_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = first_reg ? ST_INIT : ST_COMPARE;
                end
            end
            ST_INIT:
            begin
                cmd.init = 1'b1;
                phase_next = 1'b0;
                state_next = ST_MUL;
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                phase_next = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_DIV_A;
            end
            ST_DIV_A:
            begin
                cmd.div_a = 1'b1;
                state_next = status.inf ? ST_SCORE : ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (status.div_done)
                begin
                    cmd.acc_add = 1'b1;
                    state_next = status.no_prior ? ST_DIV_B : ST_SCORE;
                end
            end
            ST_DIV_B:
            begin
                cmd.div_b = 1'b1;
                state_next = ST_WAIT_B;
            end
            ST_WAIT_B:
            begin
                if (status.div_done)
                begin
                    cmd.acc_add = 1'b1;
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                if (!phase_reg)
                begin
                    cmd.set_first = 1'b1;
                    first_next = 1'b0;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmd.set_pending = 1'b1;
                    state_next = status.last ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (!status.out_busy)
                begin
                    cmd.final_out = 1'b1;
                    first_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_first_scores_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_first |-> first_reg)
        else $error("first-split score taken outside a new set");

    a_compare_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare |-> !first_reg)
        else $error("split compared on first sample");

    a_acc_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_add |-> status.div_done)
        else $error("quotient taken before divider finished");

endmodule
`default_nettype wire

// File: rtl/core/optimal_threshold_search_top.sv
// Top level of the streaming decision-stump threshold search.
`timescale 1ns / 1ps
`default_nettype none
// Samples enter one transaction at a time, sorted by value; the block keeps the
// best split and emits threshold and score after the sample flagged by s_tlast.
// Each sample is scored by a shared restoring divider that retires one quotient
// bit per cycle. The error-without-prior criterion needs two divisions per
// sample, and the first sample of a set scores twice; infinite scores skip the
// divider. A result waits in an output register while the next set streams in.
// Configuration writes are taken every cycle.
module optimal_threshold_search_top
    import ots_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] sample_value, [63:32] sample_weight
    input  wire logic        s_tuser,   // [0] sample_class
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] best_threshold, [63:32] best_score
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cmd_t        cmd;
    status_t     status;
    logic [31:0] thr;
    logic [31:0] score;

    assign cfg_ready = 1'b1;

    ots_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ots_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_class      (s_tuser),
        .in_value      (s_tdata[31:0]),
        .in_weight     (s_tdata[63:32]),
        .in_last       (s_tlast),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_threshold (thr),
        .out_score     (score)
    );

    assign m_tdata = {score, thr};

endmodule
`default_nettype wire
